// ----- sv/skl_pkg.sv -----
// ----------------------------------------------------------------------------
// skl_pkg
// shared widths, command and status codes for the sorted key list engine
// ----------------------------------------------------------------------------
package skl_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int KEY_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

endpackage

// ----- sv/sorted_key_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_list_engine_unit
// ascending list of 8-bit keys with insert and delete commands
// ----------------------------------------------------------------------------
// Each command item returns one result item with a status, the key count
// after the command and the smallest stored key (zero when the list is
// empty). Keys live in a single memory with one read and one write port; a
// command walks it entry by entry (read, then compare and move).
// A new command is taken only once the previous one has finished its walk
// and its result has entered the output register; a finished result may
// still wait in the output register while the next command is accepted.
// ----------------------------------------------------------------------------
module sorted_key_list_engine_unit #(
    parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [skl_pkg::S_DATA_W-1:0]    s_tdata,  // key[7:0]
    input  logic [0:0]                      s_tuser,  // cmd[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [skl_pkg::M_DATA_W-1:0]    m_tdata   // status[2:0], entry_count[7:3],
                                                      // smallest_key[15:8]
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_PUT   = 3'd3;
    localparam logic [2:0] ST_TOP   = 3'd4;
    localparam logic [2:0] ST_SMALL = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic                           found_reg, found_next;
    logic                           cmd_reg, cmd_next;
    logic [skl_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [skl_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [skl_pkg::M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_waddr;
    logic [skl_pkg::KEY_W-1:0]      mem_wdata;
    logic                           mem_re;
    logic [ADDR_W-1:0]              mem_raddr;
    logic [skl_pkg::KEY_W-1:0]      mem_rdata;

    logic                           s_accept;
    logic                           out_free;
    logic [CNT_W-1:0]               idx_inc;
    logic [CNT_W-1:0]               idx_dec;
    logic                           hit;
    logic [skl_pkg::KEY_W-1:0]      smallest;

    skl_store #(
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign hit      = (mem_rdata == key_reg);
    assign smallest = (count_reg == '0) ? '0 : mem_rdata;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[ADDR_W-1:0];
        mem_wdata     = mem_rdata;
        mem_re        = 1'b0;
        mem_raddr     = idx_reg[ADDR_W-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next   = s_tuser[0];
                    key_next   = s_tdata[skl_pkg::KEY_W-1:0];
                    found_next = 1'b0;
                    if (s_tuser[0] == skl_pkg::CMD_INSERT) begin
                        idx_next = count_reg;
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = skl_pkg::STAT_FULL;
                            state_next  = ST_TOP;
                        end else if (count_reg == '0) begin
                            state_next = ST_PUT;
                        end else begin
                            state_next = ST_RD;
                        end
                    end else begin
                        idx_next = '0;
                        if (count_reg == '0) begin
                            status_next = skl_pkg::STAT_EMPTY;
                            state_next  = ST_TOP;
                        end else begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_RD: begin
                mem_re = 1'b1;
                if (cmd_reg == skl_pkg::CMD_INSERT) begin
                    mem_raddr = idx_dec[ADDR_W-1:0];
                end
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (cmd_reg == skl_pkg::CMD_INSERT) begin
                    mem_we = 1'b1;
                    if (mem_rdata >= key_reg) begin
                        // move the key that is not smaller than the new key up one place
                        idx_next   = idx_dec;
                        state_next = (idx_dec == '0) ? ST_PUT : ST_RD;
                    end else begin
                        mem_wdata   = key_reg;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = skl_pkg::STAT_INSERTED;
                        state_next  = ST_TOP;
                    end
                end else begin
                    if (found_reg) begin
                        // close the gap left by the removed key
                        mem_we    = 1'b1;
                        mem_waddr = idx_dec[ADDR_W-1:0];
                    end else if (hit) begin
                        found_next = 1'b1;
                    end
                    idx_next = idx_inc;
                    if (idx_inc == count_reg) begin
                        if (found_reg || hit) begin
                            count_next  = count_reg - CNT_W'(1);
                            status_next = skl_pkg::STAT_DELETED;
                        end else begin
                            status_next = skl_pkg::STAT_NOT_FOUND;
                        end
                        state_next = ST_TOP;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_PUT: begin
                mem_we      = 1'b1;
                mem_wdata   = key_reg;
                count_next  = count_reg + CNT_W'(1);
                status_next = skl_pkg::STAT_INSERTED;
                state_next  = ST_TOP;
            end
            ST_TOP: begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_SMALL;
            end
            ST_SMALL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {smallest, skl_pkg::COUNT_W'(count_reg), status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |->
            (count_reg == CNT_W'($past(count_reg) + CNT_W'(1)) ||
             count_reg == CNT_W'($past(count_reg) - CNT_W'(1))))
        else $error("key count moved by more than one");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_TOP || state_reg == ST_SMALL) |-> !mem_we)
        else $error("memory written outside a walk");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) && (m_tdata_reg[skl_pkg::STATUS_W-1:0] == skl_pkg::STAT_EMPTY)
            |-> (count_reg == '0))
        else $error("empty status with keys stored");
`endif

endmodule

// ----- sv/skl_store.sv -----
// ----------------------------------------------------------------------------
// skl_store
// key storage: one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module skl_store #(
    parameter int DEPTH = skl_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [skl_pkg::KEY_W-1:0]           wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [skl_pkg::KEY_W-1:0]           rd_data
);

    logic [skl_pkg::KEY_W-1:0] mem [DEPTH];
    logic [skl_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- bench/skl_list_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skl_list_checker
// watches the command and result streams of the sorted key list engine,
// keeps its own ascending key list, predicts the status, key count and
// smallest key for every accepted command and compares each result item
// with the oldest prediction
// ----------------------------------------------------------------------------
module skl_list_checker #(
    parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [skl_pkg::S_DATA_W-1:0]    s_tdata,  // key[7:0]
    input  logic [0:0]                      s_tuser,  // cmd[0]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [skl_pkg::M_DATA_W-1:0]    m_tdata,  // status[2:0], entry_count[7:3],
                                                      // smallest_key[15:8]
    output int                              mismatch_count,
    output int                              results_pending
);
    import skl_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic [KEY_W-1:0]    smallest_key;
    } list_result_t;

    logic [KEY_W-1:0] list_keys [CAPACITY];
    int               list_len;
    list_result_t     expected_results [$];

    task automatic apply_list_command(input logic cmd, input logic [KEY_W-1:0] key,
                                      output list_result_t res);
        int pos;
        pos = 0;
        if (cmd == CMD_INSERT) begin
            if (list_len >= CAPACITY) begin
                res.status = STAT_FULL;
            end else begin
                while (pos < list_len && key > list_keys[pos])
                    pos++;
                for (int i = list_len; i > pos; i--)
                    list_keys[i] = list_keys[i-1];
                list_keys[pos] = key;
                list_len++;
                res.status = STAT_INSERTED;
            end
        end else begin
            if (list_len == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                while (pos < list_len && list_keys[pos] != key)
                    pos++;
                if (pos >= list_len) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_keys[i] = list_keys[i+1];
                    list_len--;
                    res.status = STAT_DELETED;
                end
            end
        end
        res.entry_count  = list_len[COUNT_W-1:0];
        res.smallest_key = (list_len > 0) ? list_keys[0] : '0;
    endtask

    initial begin
        list_len        = 0;
        mismatch_count  = 0;
        results_pending = 0;
    end

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn) begin
            // results first: a result never belongs to a command taken at the same edge
            if (m_tvalid && m_tready) begin
                got.status       = m_tdata[2:0];
                got.entry_count  = m_tdata[7:3];
                got.smallest_key = m_tdata[15:8];
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("checker: unexpected result item status=%0d count=%0d min=%0d",
                                 got.status, got.entry_count, got.smallest_key);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        // status/count/min
                        if (mismatch_count < 10)
                            $display("checker: mismatch %0t exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime,
                                     want.status, want.entry_count, want.smallest_key,
                                     got.status, got.entry_count, got.smallest_key);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_list_command(s_tuser[0], s_tdata[KEY_W-1:0], want);
                expected_results.push_back(want);
            end
            results_pending = expected_results.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the sorted key list engine: a directed run through empty,
// absent, duplicate, zero and full cases, then random insert and delete
// commands in bursts of varying mix so the list swings between empty and
// full, under changing idle patterns on both streams and one long output
// stall; checking is done by skl_list_checker
// ----------------------------------------------------------------------------
module tb;
    import skl_pkg::*;

    localparam int RANDOM_PER_PHASE = 475;
    localparam int HOLD_LEN         = 300;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;

    int   mismatch_count;
    int   results_pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_req;
    logic hold_done;
    int   hold_cycles;

    sorted_key_list_engine_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    skl_list_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

    // s_tready only moves at the rising edge, so its value at the falling
    // edge tells whether the item goes in at the next rising edge
    task automatic offer_command(input logic cmd, input logic [KEY_W-1:0] key);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        while (!s_tready)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    // receiver side, with one long hold-off on request
    initial begin
        hold_done   = 1'b0;
        hold_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_cycles++;
                if (hold_cycles == HOLD_LEN)
                    hold_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int               insert_pct;
        int               guard;
        logic             cmd;
        logic [KEY_W-1:0] key;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        hold_req    = 1'b0;
        tx_idle_pct = 12;
        rx_idle_pct = 48;
        insert_pct  = 50;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty list, extremes, duplicates, key zero, absent key
        offer_command(CMD_DELETE, 8'd0);
        offer_command(CMD_INSERT, 8'd255);
        offer_command(CMD_INSERT, 8'd0);
        offer_command(CMD_INSERT, 8'd0);
        offer_command(CMD_DELETE, 8'd7);
        offer_command(CMD_DELETE, 8'd0);
        // fill to capacity, then overflow
        for (int i = 0; i < CAPACITY_DEF - 2; i++)
            offer_command(CMD_INSERT, 8'(i * 37 + 11));
        offer_command(CMD_INSERT, 8'd128);
        offer_command(CMD_DELETE, 8'd255);
        offer_command(CMD_DELETE, 8'd0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 12; rx_idle_pct = 48; end
                1: begin tx_idle_pct = 48; rx_idle_pct = 12; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 3))
                        0: insert_pct = 20;
                        1: insert_pct = 50;
                        2: insert_pct = 75;
                        default: insert_pct = 92;
                    endcase
                end
                if (phase == 2 && n == 100)
                    hold_req = 1'b1;
                cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
                // a small key pool makes deletes hit and duplicates common
                if ($urandom_range(0, 99) < 60)
                    key = 8'($urandom_range(0, 7) * 36 + $urandom_range(0, 3));
                else
                    key = 8'($urandom_range(0, 255));
                offer_command(cmd, key);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        guard = 0;
        while (results_pending != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
